// ===== src/snl_pkg.sv =====
// Shared types, constants and per-stage step functions of the surface normal line generator.
// Used by every module of the block; depends on nothing.
package snl_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int T_W        = FRAC_BITS + 1;
    localparam int H_W        = FRAC_BITS + 3;
    localparam int ROOT_STEPS = 32;
    localparam int RAT_BITS   = FRAC_BITS + 1;
    localparam int RAT_W      = 32 + FRAC_BITS;
    localparam int PRE_W      = RAT_W + 1;
    localparam int QUOT_BITS  = 33;
    localparam int IN_W       = 256;
    localparam int OUT_W      = 224;

    localparam logic [T_W-1:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [2:0] {
        REG_SHOW      = 3'd0,
        REG_LENGTH    = 3'd1,
        REG_START     = 3'd2,
        REG_STRIDE    = 3'd3,
        REG_CONST_SEL = 3'd4,
        REG_RGBA      = 3'd5,
        REG_CH_MIN    = 3'd6,
        REG_CH_MAX    = 3'd7
    } snl_reg_t;

    typedef logic [2:0][31:0] snl_vec_t;

    // Settings as seen by the datapath, partly precomputed from the registers.
    typedef struct packed {
        logic        show;
        logic        use_const;
        logic [31:0] len;
        logic [31:0] rgba;
        logic [31:0] first;
        logic [15:0] stride;
        logic [31:0] cmin;
        logic [31:0] rmag;
        logic        rneg;
        logic        rzero;
    } snl_cfg_t;

    typedef struct packed {
        logic [31:0]      idx;
        snl_vec_t         pos;
        logic [2:0]       neg;
        logic [2:0][63:0] prod;
        logic [2:0][63:0] sq;
        logic [32:0]      diff;
    } snl_front_t;

    typedef struct packed {
        logic [31:0]         idx;
        logic [15:0]         rem_mod;
        logic [63:0]         rad;
        logic [63:0]         root;
        logic [RAT_W-1:0]    rat_rem;
        logic [RAT_BITS-1:0] rat_q;
        logic                t_one;
        logic                t_zero;
        snl_vec_t            pos;
        logic [2:0]          neg;
        logic [2:0][63:0]    prod;
    } snl_root_t;

    typedef struct packed {
        logic [31:0]                 norm;
        logic [2:0][63:0]            rem;
        logic [2:0][QUOT_BITS-1:0]   quot;
        logic [T_W-1:0]              t;
        snl_vec_t                    pos;
        logic [2:0]                  neg;
    } snl_div_t;

    // One square root digit, one index remainder bit and (in the upper steps) one ratio bit.
    function automatic snl_root_t snl_root_step(input snl_root_t a, input int k,
                                                input logic [15:0] stride,
                                                input logic [31:0] rmag);
        snl_root_t        r;
        logic [63:0]      bitv;
        logic [63:0]      trial;
        logic [16:0]      mtmp;
        logic [RAT_W-1:0] dvs;
        r     = a;
        bitv  = 64'd1 << (2 * k);
        trial = a.root + bitv;
        if (a.rad >= trial)
        begin
            r.rad  = a.rad - trial;
            r.root = (a.root >> 1) + bitv;
        end
        else
        begin
            r.root = a.root >> 1;
        end
        mtmp = {a.rem_mod, a.idx[31]};
        if (mtmp >= {1'b0, stride})
        begin
            mtmp = mtmp - {1'b0, stride};
        end
        r.rem_mod = mtmp[15:0];
        r.idx     = {a.idx[30:0], 1'b0};
        if (k >= ROOT_STEPS - RAT_BITS)
        begin
            dvs = RAT_W'(rmag) << (k - (ROOT_STEPS - RAT_BITS));
            if (a.rat_rem >= dvs)
            begin
                r.rat_rem = a.rat_rem - dvs;
                r.rat_q[k - (ROOT_STEPS - RAT_BITS)] = 1'b1;
            end
        end
        return r;
    endfunction

    // One restoring quotient bit for each of the three axes.
    function automatic snl_div_t snl_div_step(input snl_div_t a, input int j);
        snl_div_t    r;
        logic [63:0] dvs;
        r   = a;
        dvs = {32'b0, a.norm} << j;
        for (int i = 0; i < 3; i++)
        begin
            if (a.rem[i] >= dvs)
            begin
                r.rem[i]     = a.rem[i] - dvs;
                r.quot[i][j] = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

// ===== src/snl_front.sv =====
// Input stages: point gating, squares and length products, then radicand sum and ratio setup.
// Depends on snl_pkg.
module snl_front import snl_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            in_valid,
    input  logic [IN_W-1:0] in_data,
    input  logic            in_flag,
    input  snl_cfg_t        cfg,
    output logic            out_live,
    output snl_root_t       out_item
);

    logic       a_live_reg, a_live_next;
    snl_front_t a_reg, a_next;
    logic       b_live_reg, b_live_next;
    snl_root_t  b_reg, b_next;

    always_comb
    begin
        logic [31:0] dmag;
        logic [31:0] dv;
        logic        dzero;
        a_next.idx = in_data[31:0];
        dzero      = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            a_next.pos[i] = in_data[32 + 32*i +: 32];
            dv            = in_data[128 + 32*i +: 32];
            a_next.neg[i] = dv[31];
            dmag          = dv[31] ? (32'd0 - dv) : dv;
            a_next.prod[i] = 64'(cfg.len) * 64'(dmag);
            a_next.sq[i]   = 64'(dmag) * 64'(dmag);
            if (dv != 32'd0)
            begin
                dzero = 1'b0;
            end
        end
        a_next.diff = {in_data[255], in_data[255:224]} - {cfg.cmin[31], cfg.cmin};
        a_live_next = in_valid && cfg.show && in_flag && !dzero;
    end

    always_comb
    begin
        logic [31:0]      dmag;
        logic [RAT_W-1:0] numm;
        logic             one_flag;
        dmag     = a_reg.diff[32] ? 32'(33'd0 - a_reg.diff) : a_reg.diff[31:0];
        numm     = {dmag, {FRAC_BITS{1'b0}}};
        one_flag = cfg.rzero || (a_reg.diff[32] != cfg.rneg);
        b_next.idx     = a_reg.idx;
        b_next.rem_mod = '0;
        b_next.rad     = a_reg.sq[0] + a_reg.sq[1] + a_reg.sq[2];
        b_next.root    = '0;
        b_next.rat_rem = numm;
        b_next.rat_q   = '0;
        b_next.t_one   = one_flag;
        // ratio at or above 2^(FRAC_BITS+1) clamps t to zero
        b_next.t_zero  = !one_flag && ({1'b0, numm} >= (PRE_W'(cfg.rmag) << RAT_BITS));
        b_next.pos     = a_reg.pos;
        b_next.neg     = a_reg.neg;
        b_next.prod    = a_reg.prod;
        // first drawn index is a derived setting, so it is checked one stage in
        b_live_next    = a_live_reg && (a_reg.idx >= cfg.first);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_live_reg <= 1'b0;
            b_live_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_live_reg <= a_live_next;
            b_live_reg <= b_live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    assign out_live = b_live_reg;
    assign out_item = b_reg;

endmodule

// ===== src/snl_root.sv =====
// Square root pipeline of the normal length, with index remainder and color ratio bits alongside.
// Depends on snl_pkg.
module snl_root import snl_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  snl_cfg_t  cfg,
    input  logic      in_live,
    input  snl_root_t in_item,
    output logic      out_live,
    output snl_root_t out_item
);

    logic [ROOT_STEPS-1:0] live_reg;
    snl_root_t             item_reg [ROOT_STEPS];

    for (genvar g = 0; g < ROOT_STEPS; g++)
    begin : g_step
        logic      prev_live;
        snl_root_t prev_item;
        snl_root_t item_next;

        if (g == 0)
        begin : g_first
            assign prev_live = in_live;
            assign prev_item = in_item;
        end
        else
        begin : g_rest
            assign prev_live = live_reg[g-1];
            assign prev_item = item_reg[g-1];
        end

        assign item_next = snl_root_step(prev_item, ROOT_STEPS - 1 - g, cfg.stride, cfg.rmag);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                live_reg[g] <= 1'b0;
            end
            else if (advance)
            begin
                live_reg[g] <= prev_live;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                item_reg[g] <= item_next;
            end
        end
    end

    assign out_live = live_reg[ROOT_STEPS-1];
    assign out_item = item_reg[ROOT_STEPS-1];

endmodule

// ===== src/snl_div.sv =====
// Rounded offset division: length times normal component over the norm, one bit per stage.
// Depends on snl_pkg.
module snl_div import snl_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  logic      in_live,
    input  snl_root_t in_item,
    output logic      out_live,
    output snl_div_t  out_item
);

    logic                 c_live_reg, c_live_next;
    snl_div_t             c_reg, c_next;
    logic [QUOT_BITS-1:0] live_reg;
    snl_div_t             item_reg [QUOT_BITS];

    always_comb
    begin
        logic [31:0] norm;
        norm        = in_item.root[31:0];
        c_next.norm = norm;
        for (int i = 0; i < 3; i++)
        begin
            c_next.rem[i]  = in_item.prod[i] + {33'b0, norm[31:1]};
            c_next.quot[i] = '0;
        end
        if (in_item.t_one)
        begin
            c_next.t = T_ONE;
        end
        else if (in_item.t_zero || (in_item.rat_q >= T_ONE))
        begin
            c_next.t = '0;
        end
        else
        begin
            c_next.t = T_ONE - in_item.rat_q;
        end
        c_next.pos  = in_item.pos;
        c_next.neg  = in_item.neg;
        c_live_next = in_live && (in_item.rem_mod == 16'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_live_reg <= 1'b0;
        end
        else if (advance)
        begin
            c_live_reg <= c_live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_reg <= c_next;
        end
    end

    for (genvar g = 0; g < QUOT_BITS; g++)
    begin : g_step
        logic     prev_live;
        snl_div_t prev_item;
        snl_div_t item_next;

        if (g == 0)
        begin : g_first
            assign prev_live = c_live_reg;
            assign prev_item = c_reg;
        end
        else
        begin : g_rest
            assign prev_live = live_reg[g-1];
            assign prev_item = item_reg[g-1];
        end

        assign item_next = snl_div_step(prev_item, QUOT_BITS - 1 - g);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                live_reg[g] <= 1'b0;
            end
            else if (advance)
            begin
                live_reg[g] <= prev_live;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                item_reg[g] <= item_next;
            end
        end
    end

    assign out_live = live_reg[QUOT_BITS-1];
    assign out_item = item_reg[QUOT_BITS-1];

endmodule

// ===== src/snl_back.sv =====
// Output stage: signed tip with saturation, rainbow or constant color, output word register.
// Depends on snl_pkg.
module snl_back import snl_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  snl_cfg_t         cfg,
    input  logic             in_live,
    input  snl_div_t         in_item,
    output logic             out_valid,
    output logic [OUT_W-1:0] out_data
);

    logic             valid_reg;
    logic [OUT_W-1:0] data_reg, data_next;

    function automatic logic [7:0] to_byte(input logic [T_W-1:0] c);
        logic [T_W+7:0] w;
        w = {c, 8'b0} - {8'b0, c} + ((T_W + 8)'(1) << (FRAC_BITS - 1));
        return w[FRAC_BITS+7:FRAC_BITS];
    endfunction

    always_comb
    begin
        logic [34:0]          s;
        logic [34:0]          off;
        logic [2:0][31:0]     tip;
        logic [H_W-1:0]       h;
        logic [2:0]           band;
        logic [T_W-1:0]       f;
        logic [T_W-1:0]       n;
        logic [T_W-1:0]       r;
        logic [T_W-1:0]       g;
        logic [T_W-1:0]       b;
        logic [31:0]          rgba;
        for (int i = 0; i < 3; i++)
        begin
            off = {2'b0, in_item.quot[i]};
            if (in_item.neg[i])
            begin
                off = 35'd0 - off;
            end
            s = {{3{in_item.pos[i][31]}}, in_item.pos[i]} + off;
            if (s[34:31] == 4'b0000 || s[34:31] == 4'b1111)
            begin
                tip[i] = s[31:0];
            end
            else if (s[34])
            begin
                tip[i] = 32'h8000_0000;
            end
            else
            begin
                tip[i] = 32'h7FFF_FFFF;
            end
        end

        h    = (H_W'(in_item.t) << 2) + H_W'(in_item.t) + H_W'(T_ONE);
        band = h[H_W-1:FRAC_BITS];
        f    = {1'b0, h[FRAC_BITS-1:0]};
        if (!band[0])
        begin
            f = T_ONE - f;
        end
        n = T_ONE - f;
        case (band)
            3'd0, 3'd1:
            begin
                r = n;     g = '0;    b = T_ONE;
            end
            3'd2:
            begin
                r = '0;    g = n;     b = T_ONE;
            end
            3'd3:
            begin
                r = '0;    g = T_ONE; b = n;
            end
            3'd4:
            begin
                r = n;     g = T_ONE; b = '0;
            end
            default:
            begin
                r = T_ONE; g = n;     b = '0;
            end
        endcase
        // packed as alpha, blue, green, red from the top byte down
        if (cfg.use_const)
        begin
            rgba = {cfg.rgba[7:0], cfg.rgba[15:8], cfg.rgba[23:16], cfg.rgba[31:24]};
        end
        else
        begin
            rgba = {8'hFF, to_byte(b), to_byte(g), to_byte(r)};
        end
        data_next = {rgba, tip[2], tip[1], tip[0],
                     in_item.pos[2], in_item.pos[1], in_item.pos[0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_live;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== src/surface_normal_line_generator_core.sv =====
// Top level of the surface normal line generator: settings registers, pipeline control.
// Depends on snl_pkg, snl_front, snl_root, snl_div and snl_back.
//
// Usage:
//  - Points enter on the s_ stream, one word per point; position_valid rides on s_tuser.
//    Line words leave on the m_ stream: begin point, tip point and start color.
//  - Points that are not drawn (hidden normals, index off the start/stride grid, invalid
//    position, zero normal) produce no output word.
//  - Settings are written through cfg_we / cfg_index / cfg_data while no point is in flight.
//  - From input acceptance to m_tvalid a point passes two input stages, 32 square root
//    stages (one root digit each), one setup stage, 33 divider stages (one quotient bit each)
//    and the output register. Throughput is one point per cycle while the output is not stalled.
//  - A stalled receiver holds the output word and freezes the whole pipeline; s_tready drops
//    only while the output register holds a word that is not being taken.
//  - Reset empties the pipeline and loads the default settings (normals shown, length 1.0,
//    start 0, stride 1, constant white color, channel range 0.0 to 1.0).
module surface_normal_line_generator_core import snl_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // point_index, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, channel_value
    input  logic [IN_W-1:0]  s_tdata,
    // position_valid
    input  logic             s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // begin_x, begin_y, begin_z, tip_x, tip_y, tip_z, color_red, color_green, color_blue,
    // color_alpha
    output logic [OUT_W-1:0] m_tdata,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_data
);

    logic        show_reg;
    logic [31:0] len_reg;
    logic [15:0] start_reg;
    logic [15:0] stride_reg;
    logic        const_sel_reg;
    logic [31:0] rgba_reg;
    logic [31:0] cmin_reg;
    logic [31:0] cmax_reg;

    logic [31:0] first_reg, first_next;
    logic [15:0] stride_eff_reg, stride_eff_next;
    logic [32:0] range_reg, range_next;
    snl_cfg_t    cfg;

    logic        advance;
    logic        front_live, root_live, div_live;
    snl_root_t   front_item, root_item;
    snl_div_t    div_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            show_reg      <= 1'b1;
            len_reg       <= 32'h0001_0000;
            start_reg     <= 16'd0;
            stride_reg    <= 16'd1;
            const_sel_reg <= 1'b1;
            rgba_reg      <= 32'hFFFF_FFFF;
            cmin_reg      <= 32'd0;
            cmax_reg      <= 32'h0001_0000;
        end
        else if (cfg_we)
        begin
            case (snl_reg_t'(cfg_index))
                REG_SHOW:      show_reg      <= cfg_data[0];
                REG_LENGTH:    len_reg       <= cfg_data;
                REG_START:     start_reg     <= cfg_data[15:0];
                REG_STRIDE:    stride_reg    <= cfg_data[15:0];
                REG_CONST_SEL: const_sel_reg <= cfg_data[0];
                REG_RGBA:      rgba_reg      <= cfg_data;
                REG_CH_MIN:    cmin_reg      <= cfg_data;
                REG_CH_MAX:    cmax_reg      <= cfg_data;
                default:       show_reg      <= show_reg;
            endcase
        end
    end

    // derived settings, held in registers fed from the settings registers
    assign stride_eff_next = (stride_reg == 16'd0) ? 16'd1 : stride_reg;
    assign first_next      = 32'(start_reg) * 32'(stride_eff_next);
    assign range_next      = {cmax_reg[31], cmax_reg} - {cmin_reg[31], cmin_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg      <= 32'd0;
            stride_eff_reg <= 16'd1;
            range_reg      <= 33'h0_0001_0000;
        end
        else
        begin
            first_reg      <= first_next;
            stride_eff_reg <= stride_eff_next;
            range_reg      <= range_next;
        end
    end

    always_comb
    begin
        cfg.show      = show_reg;
        cfg.use_const = const_sel_reg;
        cfg.len       = len_reg;
        cfg.rgba      = rgba_reg;
        cfg.first     = first_reg;
        cfg.stride    = stride_eff_reg;
        cfg.cmin      = cmin_reg;
        cfg.rmag      = range_reg[32] ? 32'(33'd0 - range_reg) : range_reg[31:0];
        cfg.rneg      = range_reg[32];
        cfg.rzero     = (range_reg == 33'd0);
    end

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    snl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .in_flag  (s_tuser),
        .cfg      (cfg),
        .out_live (front_live),
        .out_item (front_item)
    );

    snl_root u_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .cfg      (cfg),
        .in_live  (front_live),
        .in_item  (front_item),
        .out_live (root_live),
        .out_item (root_item)
    );

    snl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_live  (root_live),
        .in_item  (root_item),
        .out_live (div_live),
        .out_item (div_item)
    );

    snl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .cfg       (cfg),
        .in_live   (div_live),
        .in_item   (div_item),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

    a_stall_only_on_held_word: assert property (
        @(posedge clk) disable iff (!rst_n) !s_tready |-> m_tvalid)
        else $error("input stalled with no word held at the output");

    a_stride_nonzero: assert property (
        @(posedge clk) disable iff (!rst_n) stride_eff_reg != 16'd0)
        else $error("effective stride is zero");

    a_word_leaves_on_take: assert property (
        @(posedge clk) disable iff (!rst_n) $fell(m_tvalid) |-> $past(m_tready))
        else $error("output word dropped without being taken");

endmodule

// ===== verif/surface_normal_line_generator_core_tb.sv =====
// Testbench for surface_normal_line_generator_core: drives points, predicts line words
// with an internal model of the draw filter, normal scaling and color map. Depends on snl_pkg.
`timescale 1ns / 100ps

module surface_normal_line_generator_core_tb;
    import snl_pkg::*;

    localparam int LATENCY = 69;

    typedef struct {
        logic [31:0] idx;
        logic        pvalid;
        logic [31:0] px, py, pz, dx, dy, dz, chan;
    } point_t;

    typedef struct packed {
        logic [31:0] bx, by, bz, tx, ty, tz;
        logic [7:0]  r, g, b, a;
    } line_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_we;
    logic [2:0]        cfg_index;
    logic [31:0]       cfg_data;

    // shadow copies of the settings
    logic        sh_show;
    logic [31:0] sh_len;
    logic [15:0] sh_start;
    logic [15:0] sh_stride;
    logic        sh_const;
    logic [31:0] sh_rgba;
    logic [31:0] sh_cmin;
    logic [31:0] sh_cmax;

    line_t expected_lines[$];
    int    mismatches;
    int    lines_seen;
    int    points_sent;
    bit    idle_enable;

    surface_normal_line_generator_core DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] magnitude(input logic [31:0] d);
        longint s;
        s = longint'($signed(d));
        return (s < 0) ? 64'(-s) : 64'(s);
    endfunction

    function automatic logic [31:0] tip_coord(input logic [31:0] p, input logic [31:0] d,
                                              input logic [63:0] norm);
        logic [63:0] prod;
        longint      off;
        longint      t;
        prod = 64'(sh_len) * magnitude(d);
        off  = longint'((prod + norm / 2) / norm);
        if ($signed(d) < 0) off = -off;
        t = longint'($signed(p)) + off;
        if (t > 64'sd2147483647) t = 64'sd2147483647;
        if (t < -64'sd2147483648) t = -64'sd2147483648;
        return t[31:0];
    endfunction

    function automatic logic [7:0] q_to_byte(input longint c);
        longint v;
        v = (c * 255 + (1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
        return v[7:0];
    endfunction

    // returns 1 and fills the line when the point is drawn
    function automatic bit predict_line(input point_t p, output line_t l);
        logic [63:0] stride, first, sum, norm;
        longint one, v, rng, t, h, f, n, r, g, b, band, ratio;
        one    = longint'(1) << FRAC_BITS;
        l      = '{default: '0};
        stride = (sh_stride == 0) ? 64'd1 : 64'(sh_stride);
        first  = 64'(sh_start) * stride;
        if (!sh_show) return 0;
        if (64'(p.idx) < first || (64'(p.idx) % stride) != 0) return 0;
        if (!p.pvalid) return 0;
        sum = magnitude(p.dx) * magnitude(p.dx) + magnitude(p.dy) * magnitude(p.dy)
              + magnitude(p.dz) * magnitude(p.dz);
        if (sum == 0) return 0;
        norm = int_sqrt(sum);
        l.bx = p.px; l.by = p.py; l.bz = p.pz;
        l.tx = tip_coord(p.px, p.dx, norm);
        l.ty = tip_coord(p.py, p.dy, norm);
        l.tz = tip_coord(p.pz, p.dz, norm);
        if (sh_const)
        begin
            {l.r, l.g, l.b, l.a} = sh_rgba;
            return 1;
        end
        v   = longint'($signed(p.chan));
        rng = longint'($signed(sh_cmax)) - longint'($signed(sh_cmin));
        if (rng == 0)
            t = one;
        else
        begin
            ratio = ((v - longint'($signed(sh_cmin))) * one) / rng;
            t = one - ratio;
        end
        if (t > one) t = one;
        if (t < 0) t = 0;
        h    = t * 5 + one;
        band = h >>> FRAC_BITS;
        f    = h & (one - 1);
        if (band[0] == 1'b0) f = one - f;
        n = one - f;
        if (band <= 1)      begin r = n;   g = 0;   b = one; end
        else if (band == 2) begin r = 0;   g = n;   b = one; end
        else if (band == 3) begin r = 0;   g = one; b = n;   end
        else if (band == 4) begin r = n;   g = one; b = 0;   end
        else                begin r = one; g = n;   b = 0;   end
        l.r = q_to_byte(r);
        l.g = q_to_byte(g);
        l.b = q_to_byte(b);
        l.a = 8'd255;
        return 1;
    endfunction

    task automatic write_reg(input snl_reg_t idx, input logic [31:0] val);
        s_tvalid  <= 1'b0;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_SHOW:      sh_show   = val[0];
            REG_LENGTH:    sh_len    = val;
            REG_START:     sh_start  = val[15:0];
            REG_STRIDE:    sh_stride = val[15:0];
            REG_CONST_SEL: sh_const  = val[0];
            REG_RGBA:      sh_rgba   = val;
            REG_CH_MIN:    sh_cmin   = val;
            default:       sh_cmax   = val;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // s_tvalid stays high after the word is taken; a register write, a drain or an idle gap in the next call drops it
    task automatic send_point(input point_t p);
        line_t l;
        while (idle_enable && $urandom_range(99) < 31)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p.chan, p.dz, p.dy, p.dx, p.pz, p.py, p.px, p.idx};
        s_tuser  <= p.pvalid;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (predict_line(p, l)) expected_lines.insert(expected_lines.size(), l);
        points_sent++;
        @(negedge clk);
    endtask

    // drain: all results in, then let skipped points clear the pipeline
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_lines.size() != 0) @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_dir();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return $urandom_range(131072) - 65536;
            default: return $urandom;
        endcase
    endfunction

    function automatic point_t rand_point(input logic [31:0] idx);
        point_t p;
        p.idx    = idx;
        p.pvalid = ($urandom_range(9) != 0);
        p.px = $urandom; p.py = $urandom; p.pz = $urandom;
        if ($urandom_range(1)) begin p.px >>>= 8; p.py >>>= 8; p.pz >>>= 8; end
        p.dx = rand_dir(); p.dy = rand_dir(); p.dz = rand_dir();
        p.chan = ($urandom_range(1)) ? $urandom : $urandom_range(98304) - 16384;
        return p;
    endfunction

    function automatic point_t make_point(input logic [31:0] idx, input logic pv,
                                          input logic [31:0] dx, input logic [31:0] dy,
                                          input logic [31:0] dz, input logic [31:0] ch);
        point_t p;
        p = '{idx: idx, pvalid: pv, px: 32'h0001_0000, py: 32'hFFFF_0000, pz: 32'h0,
              dx: dx, dy: dy, dz: dz, chan: ch};
        return p;
    endfunction

    task automatic test_directed_edges();
        send_point(make_point(0, 1'b1, 32'h0001_0000, 0, 0, 0));
        send_point(make_point(1, 1'b0, 32'h0001_0000, 0, 0, 0));
        send_point(make_point(2, 1'b1, 0, 0, 0, 0));
        send_point(make_point(32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0000, 0));
        send_point(make_point(3, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
        send_point('{idx: 4, pvalid: 1'b1, px: 32'h7FFF_FFFF, py: 32'h8000_0000, pz: 0,
                     dx: 5, dy: -5, dz: 1, chan: 0});
        wait_idle();
        write_reg(REG_LENGTH, 32'hFFFF_FFFF);
        send_point('{idx: 5, pvalid: 1'b1, px: 32'h7FFF_0000, py: 32'h8000_1000, pz: 0,
                     dx: 1, dy: -1, dz: 0, chan: 0});
        wait_idle();
        write_reg(REG_LENGTH, 32'd0);
        send_point(make_point(6, 1'b1, 3, 4, 0, 0));
        wait_idle();
        write_reg(REG_LENGTH, 32'h0001_0000);
    endtask

    task automatic test_rainbow_bands();
        write_reg(REG_CONST_SEL, 32'd0);
        write_reg(REG_CH_MIN, 32'h0);
        write_reg(REG_CH_MAX, 32'h0001_0000);
        for (int k = -1; k <= 11; k++)
            send_point(make_point(32'(k + 10), 1'b1, 0, 0, 32'h0000_2000,
                                  k * 32'h0000_1999));
        send_point(make_point(30, 1'b1, 1, 0, 0, 32'h8000_0000));
        send_point(make_point(31, 1'b1, 1, 0, 0, 32'h7FFF_FFFF));
        wait_idle();
        write_reg(REG_CH_MAX, 32'h0);           // zero range
        send_point(make_point(32, 1'b1, 1, 0, 0, 32'h1234));
        wait_idle();
        write_reg(REG_CH_MIN, 32'h7FFF_FFFF);   // inverted range
        write_reg(REG_CH_MAX, 32'h8000_0000);
        send_point(make_point(33, 1'b1, 1, 0, 0, 32'h0));
        send_point(make_point(34, 1'b1, 1, 0, 0, 32'h7FFF_0000));
        wait_idle();
    endtask

    task automatic test_stride_and_hide();
        write_reg(REG_START, 32'd3);
        write_reg(REG_STRIDE, 32'd5);
        for (int k = 0; k < 30; k++)
            send_point(make_point(32'(k), 1'b1, 1, 1, 1, 32'(k << 12)));
        wait_idle();
        write_reg(REG_STRIDE, 32'd0);           // acts as stride one
        write_reg(REG_START, 32'h0000_FFFF);
        send_point(make_point(32'hFFFE, 1'b1, 1, 0, 0, 0));
        send_point(make_point(32'hFFFF, 1'b1, 1, 0, 0, 0));
        wait_idle();
        write_reg(REG_STRIDE, 32'h0000_FFFF);
        write_reg(REG_START, 32'h0000_FFFF);
        send_point(make_point(32'hFFFE_0001, 1'b1, 1, 0, 0, 0));
        send_point(make_point(32'hFFFF_FFFF, 1'b1, 1, 0, 0, 0));
        wait_idle();
        write_reg(REG_SHOW, 32'd0);
        for (int k = 0; k < 10; k++) send_point(rand_point(32'(k)));
        wait_idle();
        write_reg(REG_SHOW, 32'd1);
        write_reg(REG_START, 32'd0);
        write_reg(REG_STRIDE, 32'd1);
    endtask

    task automatic test_random_phase(input int count, input int stride_max);
        logic [31:0] idx;
        write_reg(REG_STRIDE, 32'($urandom_range(stride_max, 1)));
        write_reg(REG_START, 32'($urandom_range(3)));
        write_reg(REG_LENGTH, ($urandom_range(3) == 0) ? $urandom : $urandom_range(262144));
        write_reg(REG_CONST_SEL, 32'($urandom_range(1)));
        write_reg(REG_RGBA, $urandom);
        write_reg(REG_CH_MIN, $urandom_range(65536) - 32768);
        write_reg(REG_CH_MAX, ($urandom_range(4) == 0) ? $urandom : $urandom_range(131072));
        idx = $urandom_range(20);
        for (int k = 0; k < count; k++)
        begin
            if (k == count / 2) wait_idle();    // sender holds until pipeline drains
            send_point(rand_point(($urandom_range(9) == 0) ? $urandom : idx));
            idx++;
        end
        wait_idle();
    endtask

    // output side: random backpressure
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= !(idle_enable && $urandom_range(99) < 31);
        end
    end

    // unpack and compare each line word taken
    always @(posedge clk)
    begin
        line_t got;
        line_t exp_l;
        if (rst_n && m_tvalid && m_tready)
        begin
            {got.a, got.b, got.g, got.r, got.tz, got.ty, got.tx, got.bz, got.by, got.bx}
                = m_tdata;
            lines_seen++;
            if (expected_lines.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected line word %h", m_tdata);
            end
            else
            begin
                exp_l = expected_lines.pop_front();
                if (got != exp_l)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("line mismatch: exp %h %h %h %h %h %h %h %h %h %h got %h",
                                 exp_l.bx, exp_l.by, exp_l.bz, exp_l.tx, exp_l.ty, exp_l.tz,
                                 exp_l.r, exp_l.g, exp_l.b, exp_l.a, m_tdata);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
        cfg_we = 1'b0; cfg_index = REG_SHOW; cfg_data = '0;
        mismatches = 0; lines_seen = 0; points_sent = 0; idle_enable = 1'b1;
        sh_show = 1; sh_len = 32'h0001_0000; sh_start = 0; sh_stride = 1;
        sh_const = 1; sh_rgba = 32'hFFFF_FFFF; sh_cmin = 0; sh_cmax = 32'h0001_0000;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed_edges();
        test_rainbow_bands();
        test_stride_and_hide();
        test_random_phase(150, 1);
        idle_enable = 1'b0;                     // back-to-back stretch
        test_random_phase(150, 3);
        idle_enable = 1'b1;
        test_random_phase(150, 2);
        test_random_phase(150, 1);
        test_random_phase(150, 4);
        wait_idle();
        $display("Sent %0d points covering filter, scaling, saturation and color modes;",
                 points_sent);
        $display("checked %0d line words, %0d mismatches.", lines_seen, mismatches);
        if (mismatches == 0 && expected_lines.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
